### src/fmop_pkg.sv
// ----------------------------------------------------------------------------
// fmop_pkg: shared types, codes and tables of the FM operator
// Item structs, command and stage codes, register indexes and the
// quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
package fmop_pkg;

    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int LEVEL_BITS       = 24;

    localparam int SINE_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int SINE_XSH     = 32 - SINE_BITS;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // request commands
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

    // envelope stages
    localparam logic [2:0] ST_ATTACK  = 3'd0;
    localparam logic [2:0] ST_DECAY   = 3'd1;
    localparam logic [2:0] ST_SUSTAIN = 3'd2;
    localparam logic [2:0] ST_RELEASE = 3'd3;
    localparam logic [2:0] ST_OFF     = 3'd4;

    // waveforms
    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_TRI    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SELECT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_DEPTH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_STEP   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_STEP    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN_LEVEL = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_STEP  = 3'd7;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] modulation;
        logic [15:0]        pitch_bend;
        logic [15:0]        velocity;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [2:0]         env_phase;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic en_phase;
        logic en_wave;
        logic en_mul1;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_sounds;
    } t_dp_sts;

    typedef logic [16:0] t_sine_tab [SINE_QUARTER];

    function automatic longint mul_q30(longint a, longint b);
        logic        neg;
        logic [63:0] m;
        logic [63:0] r;
        neg = (a < 0);
        m   = neg ? 64'(-a) : 64'(a);
        r   = (m * 64'(b)) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // positive quarter-wave value at x = j / SINE_QUARTER of a quarter turn
    function automatic logic [16:0] sine_eval(int j);
        longint x;
        longint x2;
        longint p;
        longint s;
        x  = longint'(j) <<< SINE_XSH;
        x2 = mul_q30(x, x);
        p  = 172272;
        p  = -5026994 + mul_q30(p, x2);
        p  = 85569306 + mul_q30(p, x2);
        p  = -693598668 + mul_q30(p, x2);
        p  = 1686629713 + mul_q30(p, x2);
        s  = mul_q30(p, x);
        if (s < 0) begin
            s = 0;
        end
        if (s > (longint'(1) <<< 30)) begin
            s = longint'(1) <<< 30;
        end
        return 17'((s + 16384) >>> 15);
    endfunction

    function automatic t_sine_tab sine_build();
        t_sine_tab t;
        for (int i = 0; i < SINE_QUARTER; i++) begin
            t[i] = sine_eval(i);
        end
        return t;
    endfunction

    localparam t_sine_tab   SINE_TAB  = sine_build();
    localparam logic [16:0] SINE_PEAK = sine_eval(SINE_QUARTER);

endpackage

### src/fm_operator_with_adsr_core.sv
// ----------------------------------------------------------------------------
// fm_operator_with_adsr_core: one FM operator with a linear ADSR envelope
// Sequencer and datapath joined by step enables and one status bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes commands:
//   sample tick, note on, note off. Only a tick that leaves the envelope
//   sounding produces a result on the output channel (o_out_valid /
//   i_out_stall / o_out_data): the saturated sample and the envelope stage.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken and
//   belong in idle periods.
//   Note on, note off and silent ticks are done when accepted. A sounding tick
//   then runs the phase, wave, mul1 and mul2 states until the sample sits in
//   the output register, and the next request is taken only after that. The
//   states hold the phase add, the sine table lookup and the three passes
//   through the single shared gain multiplier (amplitude times velocity,
//   times waveform, times envelope).
//   Reset restores the register defaults, clears the phase and puts the
//   envelope in the off stage. While the receiver stalls, the output
//   register holds its sample; the block still accepts requests and, once
//   one of them makes a sample, waits with it in its last step.
// ----------------------------------------------------------------------------
module fm_operator_with_adsr_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fmop_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fmop_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fmop_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [fmop_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import fmop_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    fmop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    fmop_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

### src/fmop_ctrl.sv
// ----------------------------------------------------------------------------
// fmop_ctrl: sequencing of one sample tick
// Input and output handshakes, step enables for the datapath.
// ----------------------------------------------------------------------------
module fmop_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  fmop_pkg::t_dp_sts i_sts,
    output fmop_pkg::t_dp_cmd o_cmd
);
    import fmop_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_WAVE,
        S_MUL1,
        S_MUL2
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   load_out;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign load_out = (r_state == S_MUL2) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.tick_sounds) begin
                    n_state = S_PHASE;
                end
            end
            S_PHASE: n_state = S_WAVE;
            S_WAVE:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2: begin
                // hold the finished sample until the output register frees
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept   = accept;
    assign o_cmd.en_phase = (r_state == S_PHASE);
    assign o_cmd.en_wave  = (r_state == S_WAVE);
    assign o_cmd.en_mul1  = (r_state == S_MUL1);
    assign o_cmd.load_out = load_out;

endmodule

### src/fmop_dp.sv
// ----------------------------------------------------------------------------
// fmop_dp: operator datapath
// Registers, envelope step, phase accumulator, waveform and gain chain
// around one shared multiplier.
// ----------------------------------------------------------------------------
module fmop_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fmop_pkg::t_dp_cmd                     i_cmd,
    output fmop_pkg::t_dp_sts                     o_sts,
    input  fmop_pkg::t_in_item                    i_in_data,
    input  logic                                  i_cfg_we,
    input  logic [fmop_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [fmop_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output fmop_pkg::t_out_item                   o_out_data
);
    import fmop_pkg::*;

    localparam int PW   = PHASE_BITS;
    localparam int LW   = LEVEL_BITS;
    localparam int EW   = ((LW > CFG_DATA_BITS) ? LW : CFG_DATA_BITS) + 1;
    localparam int SB   = SINE_BITS;
    localparam int MA   = 33;
    localparam int MB   = (LW > 32) ? LW : 32;
    localparam int SH_L = (PW >= 27) ? PW - 27 : 0;
    localparam int SH_R = (PW >= 27) ? 0 : 27 - PW;
    localparam logic [LW-1:0] FULL = {LW{1'b1}};

    // configuration
    logic [23:0] r_phase_step;
    logic [1:0]  r_wave;
    logic [15:0] r_amp;
    logic [15:0] r_depth;
    logic [23:0] r_att;
    logic [23:0] r_dec;
    logic [23:0] r_sus;
    logic [23:0] r_rel;

    // voice state
    logic [PW-1:0] r_phase_acc;
    logic [LW-1:0] r_level;
    logic [2:0]    r_stage;
    logic [15:0]   r_vel;

    // working registers
    logic signed [32:0] r_mod_prod;
    logic [PW-1:0]      r_adv;
    logic [PW-1:0]      r_p;
    logic [31:0]        r_av;
    logic               r_neg;
    logic [16:0]        r_mag;
    logic [MA-1:0]      r_x;
    t_out_item          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_wave       <= WAVE_SINE;
            r_amp        <= 16'd32768;
            r_depth      <= '0;
            r_att        <= 24'd1;
            r_dec        <= 24'd1;
            r_sus        <= 24'd11744051;
            r_rel        <= 24'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:    r_phase_step <= i_cfg_data[23:0];
                CFG_WAVE_SELECT:   r_wave       <= i_cfg_data[1:0];
                CFG_AMPLITUDE:     r_amp        <= i_cfg_data[15:0];
                CFG_MOD_DEPTH:     r_depth      <= i_cfg_data[15:0];
                CFG_ATTACK_STEP:   r_att        <= i_cfg_data[23:0];
                CFG_DECAY_STEP:    r_dec        <= i_cfg_data[23:0];
                CFG_SUSTAIN_LEVEL: r_sus        <= i_cfg_data[23:0];
                CFG_RELEASE_STEP:  r_rel        <= i_cfg_data[23:0];
            endcase
        end
    end

    // envelope step
    logic [EW-1:0] lvl_e, full_e, sus_e, att_e, dec_e, rel_e, sum_e, dec_diff, rel_diff;
    logic [LW-1:0] sus_l;
    logic [LW-1:0] step_level;
    logic [2:0]    step_stage;

    assign lvl_e    = EW'(r_level);
    assign full_e   = EW'(FULL);
    assign sus_e    = (EW'(r_sus) > full_e) ? full_e : EW'(r_sus);
    assign sus_l    = LW'(sus_e);
    assign att_e    = EW'(r_att);
    assign dec_e    = EW'(r_dec);
    assign rel_e    = EW'(r_rel);
    assign sum_e    = lvl_e + att_e;
    assign dec_diff = lvl_e - dec_e;
    assign rel_diff = lvl_e - rel_e;

    always_comb begin
        step_level = r_level;
        step_stage = r_stage;
        unique case (r_stage)
            ST_ATTACK: begin
                if (sum_e >= full_e) begin
                    step_level = FULL;
                    step_stage = ST_DECAY;
                end else begin
                    step_level = LW'(sum_e);
                end
            end
            ST_DECAY: begin
                if ((lvl_e < dec_e) || (dec_diff <= sus_e)) begin
                    step_level = sus_l;
                    step_stage = ST_SUSTAIN;
                end else begin
                    step_level = LW'(dec_diff);
                end
            end
            ST_SUSTAIN: step_level = sus_l;
            ST_RELEASE: begin
                if (lvl_e <= rel_e) begin
                    step_level = '0;
                    step_stage = ST_OFF;
                end else begin
                    step_level = LW'(rel_diff);
                end
            end
            default: begin
                step_level = '0;
                step_stage = ST_OFF;
            end
        endcase
    end

    assign o_sts.tick_sounds = (i_in_data.command == CMD_TICK) && (step_stage != ST_OFF);

    // modulation offset and phase increment, formed at accept
    logic signed [32:0] mod_prod_c;
    logic [39:0]        adv_full;
    logic signed [39:0] mod_ext;
    logic [PW-1:0]      offs;

    assign mod_prod_c = $signed({{17{i_in_data.modulation[15]}}, i_in_data.modulation})
                      * $signed({17'b0, r_depth});
    assign adv_full   = 40'(r_phase_step) * 40'(i_in_data.pitch_bend);
    assign mod_ext    = 40'(r_mod_prod);
    assign offs       = PW'((mod_ext <<< SH_L) >>> SH_R);

    // shared gain multiplier
    logic [MA-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [MA+MB-1:0] mul_p;

    always_comb begin
        priority if (i_cmd.en_phase) begin
            mul_a = MA'(r_amp);
            mul_b = MB'(r_vel);
        end else if (i_cmd.en_mul1) begin
            mul_a = MA'(r_mag);
            mul_b = MB'(r_av);
        end else begin
            mul_a = r_x;
            mul_b = MB'(r_level);
        end
    end

    assign mul_p = (MA + MB)'(mul_a) * (MA + MB)'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_level     <= '0;
            r_stage     <= ST_OFF;
            r_vel       <= '0;
        end else begin
            if (i_cmd.accept) begin
                unique case (i_in_data.command)
                    CMD_NOTE_ON: begin
                        r_vel   <= i_in_data.velocity;
                        r_stage <= ST_ATTACK;
                        r_level <= '0;
                    end
                    CMD_NOTE_OFF: begin
                        if (r_stage < ST_OFF) begin
                            r_stage <= ST_RELEASE;
                            r_level <= sus_l;
                        end
                    end
                    CMD_TICK: begin
                        r_stage <= step_stage;
                        r_level <= step_level;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.en_phase) begin
                r_phase_acc <= r_phase_acc + r_adv;
            end
        end
    end

    // waveform
    logic [15:0]        f16;
    logic [SB-1:0]      k;
    logic [SB-3:0]      j;
    logic [SB-3:0]      j_neg;
    logic [SB-3:0]      idx;
    logic [16:0]        sv;
    logic signed [18:0] w;

    assign f16   = r_p[PW-1 -: 16];
    assign k     = r_p[PW-1 -: SB];
    assign j     = k[SB-3:0];
    assign j_neg = ~j + 1'b1;
    assign idx   = k[SB-2] ? j_neg : j;
    assign sv    = (k[SB-2] && (j == '0)) ? SINE_PEAK : SINE_TAB[idx];

    always_comb begin
        unique case (r_wave)
            WAVE_SINE: w = k[SB-1] ? -$signed({2'b0, sv}) : $signed({2'b0, sv});
            WAVE_SAW:  w = $signed({3'b0, f16}) - 19'sd32768;
            WAVE_SQUARE: w = f16[15] ? -19'sd32768 : 19'sd32768;
            WAVE_TRI: begin
                if (!f16[15]) begin
                    w = $signed({2'b0, f16, 1'b0}) - 19'sd32768;
                end else begin
                    w = 19'sd98304 - $signed({2'b0, f16, 1'b0});
                end
            end
        endcase
    end

    // final scaling and saturation
    logic [MA+MB-1:0]   gain_sh;
    logic [17:0]        gain_mag;
    logic signed [15:0] sat;

    assign gain_sh  = mul_p >> (16 + LW);
    assign gain_mag = gain_sh[17:0];

    always_comb begin
        if (r_neg) begin
            sat = (gain_mag >= 18'd32768) ? -16'sd32768 : -$signed(gain_mag[15:0]);
        end else begin
            sat = (gain_mag >= 18'd32767) ? 16'sd32767 : $signed(gain_mag[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mod_prod <= mod_prod_c;
            r_adv      <= PW'(adv_full >> 14);
        end
        if (i_cmd.en_phase) begin
            r_p  <= r_phase_acc + offs;
            r_av <= mul_p[31:0];
        end
        if (i_cmd.en_wave) begin
            r_neg <= w[18];
            r_mag <= w[18] ? 17'(-w) : 17'(w);
        end
        if (i_cmd.en_mul1) begin
            r_x <= MA'(mul_p >> 16);
        end
        if (i_cmd.load_out) begin
            r_out.sample    <= sat;
            r_out.env_phase <= r_stage;
        end
    end

    assign o_out_data = r_out;

endmodule

### src/fmop_chk.sv
// ----------------------------------------------------------------------------
// fmop_chk: port-level checks of the FM operator
// Output handshake, stage codes and request sequencing over time.
// ----------------------------------------------------------------------------
module fmop_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fmop_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fmop_pkg::t_out_item o_out_data
);
    import fmop_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // only sounding stages are reported
    a_stage_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.env_phase == ST_ATTACK
                      || o_out_data.env_phase == ST_DECAY
                      || o_out_data.env_phase == ST_SUSTAIN
                      || o_out_data.env_phase == ST_RELEASE))
        else $error("result carries a silent stage");

    // a new result is always the end of a busy sequence
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a tick in progress");

    // a note request leaves the input free in the cycle after it
    a_note_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.command != CMD_TICK) |=> !o_in_stall)
        else $error("note request kept the input stalled");

endmodule

bind fm_operator_with_adsr_core fmop_chk u_fmop_chk (.*);

### verif/fm_operator_with_adsr_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fm_operator_with_adsr_core_tb: self-checking bench of the FM operator
// Walks a short directed script through the envelope stages and commands,
// then runs randomized note sequences under changing register settings.
// An in-bench operator model predicts each sample and stage; results are
// matched in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module fm_operator_with_adsr_core_tb;

    import fmop_pkg::*;

    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [23:0] LEVEL_MAX  = 24'hFFFFFF;
    localparam int          PHASES     = 12;
    localparam int          PHASE_ITEMS = 156;

    typedef enum logic [1:0] {ROW_CFG, ROW_REQ, ROW_PINNED} t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  val;
        t_in_item                  rq;
        t_out_item                 pinned;
    } t_script_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    t_in_item                  i_in_data = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_item                 o_out_data;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    fm_operator_with_adsr_core dut (.*);

    // operator model: registers and voice state at their reset values
    logic [23:0] r_phase_step = '0;
    logic [1:0]  r_wave       = WAVE_SINE;
    logic [15:0] r_amp        = 16'd32768;
    logic [15:0] r_depth      = '0;
    logic [23:0] r_attack     = 24'd1;
    logic [23:0] r_decay      = 24'd1;
    logic [23:0] r_sustain    = 24'd11744051;
    logic [23:0] r_release    = 24'd1;

    logic [23:0] acc_phase = '0;
    logic [23:0] env_lvl   = '0;
    logic [2:0]  env_st    = ST_OFF;
    logic [15:0] vel_held  = '0;

    t_out_item   expected_samples[$];
    t_script_row script[$];
    int          mismatches = 0;
    int          sent_items = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          stall_draw;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic void add_row(input t_script_row r);
        script.insert(script.size(), r);
    endfunction

    // Q30 product, truncating the magnitude
    function automatic longint q30_mul(input longint a, input longint b);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m * b) >>> 30;
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint sine_value(input logic [9:0] k);
        longint x;
        longint x2;
        longint acc;
        longint s;
        longint v;
        x = longint'(k[7:0]) <<< 22;
        // mirror the odd quarters
        if (k[8]) begin
            x = (longint'(1) <<< 30) - x;
        end
        x2  = q30_mul(x, x);
        acc = 172272;
        acc = -5026994 + q30_mul(acc, x2);
        acc = 85569306 + q30_mul(acc, x2);
        acc = -693598668 + q30_mul(acc, x2);
        acc = 1686629713 + q30_mul(acc, x2);
        s   = q30_mul(acc, x);
        if (s < 0) begin
            s = 0;
        end
        if (s > (longint'(1) <<< 30)) begin
            s = longint'(1) <<< 30;
        end
        v = (s + 16384) >>> 15;
        return k[9] ? -v : v;
    endfunction

    // Advance the operator model by one request; returns 1 when a sample is due.
    function automatic bit operator_step(input t_in_item rq, output t_out_item res);
        logic [24:0] sum;
        logic [23:0] p;
        logic [15:0] f16;
        longint      offs;
        longint      w;
        logic [63:0] mag;
        longint      s;
        res   = '0;
        case (rq.command)
            CMD_NOTE_ON: begin
                vel_held = rq.velocity;
                env_st   = ST_ATTACK;
                env_lvl  = '0;
                return 1'b0;
            end
            CMD_NOTE_OFF: begin
                if (env_st < ST_OFF) begin
                    env_st  = ST_RELEASE;
                    env_lvl = r_sustain;
                end
                return 1'b0;
            end
            CMD_TICK: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        if (env_st >= ST_OFF) begin
            env_st  = ST_OFF;
            env_lvl = '0;
            return 1'b0;
        end

        case (env_st)
            ST_ATTACK: begin
                sum = {1'b0, env_lvl} + {1'b0, r_attack};
                if (sum >= {1'b0, LEVEL_MAX}) begin
                    env_lvl = LEVEL_MAX;
                    env_st  = ST_DECAY;
                end else begin
                    env_lvl = sum[23:0];
                end
            end
            ST_DECAY: begin
                if (env_lvl < r_decay || (env_lvl - r_decay) <= r_sustain) begin
                    env_lvl = r_sustain;
                    env_st  = ST_SUSTAIN;
                end else begin
                    env_lvl = env_lvl - r_decay;
                end
            end
            ST_SUSTAIN: begin
                env_lvl = r_sustain;
            end
            ST_RELEASE: begin
                if (env_lvl <= r_release) begin
                    env_lvl = '0;
                    env_st  = ST_OFF;
                end else begin
                    env_lvl = env_lvl - r_release;
                end
            end
            default: begin
                env_lvl = '0;
                env_st  = ST_OFF;
            end
        endcase
        if (env_st == ST_OFF) begin
            return 1'b0;
        end

        // offset floors toward minus infinity, phase wraps modulo one turn
        offs = (longint'(rq.modulation) * longint'(r_depth)) >>> 3;
        p    = 24'(longint'(acc_phase) + offs);
        f16  = p[23:8];
        case (r_wave)
            WAVE_SINE:   w = sine_value(p[23:14]);
            WAVE_SAW:    w = longint'(f16) - 32768;
            WAVE_SQUARE: w = f16[15] ? -32768 : 32768;
            default:     w = f16[15] ? 98304 - 2 * longint'(f16)
                                     : 2 * longint'(f16) - 32768;
        endcase

        mag = 64'((w < 0) ? -w : w);
        mag = ((mag * 64'(r_amp) * 64'(vel_held)) >> 16) * 64'(env_lvl);
        mag = mag >> (16 + LEVEL_BITS);
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        s = (w < 0) ? -longint'(mag) : longint'(mag);
        if (s > 32767) begin
            s = 32767;
        end
        res.sample    = 16'(s);
        res.env_phase = env_st;

        acc_phase = acc_phase + 24'((40'(r_phase_step) * 40'(rq.pitch_bend)) >> 14);
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 24'd1;
            1:       return LEVEL_MAX;
            default: return 24'($urandom_range(24'h020000, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [23:0] pick_sustain();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return LEVEL_MAX;
            default: return 24'($urandom());
        endcase
    endfunction

    // phase 0 takes the low extremes, phase 1 all ones, the rest random values
    function automatic logic [23:0] pick_cfg(input int ph, input logic [23:0] low_val,
                                             input logic [23:0] rnd);
        if (ph == 0) begin
            return low_val;
        end
        if (ph == 1) begin
            return LEVEL_MAX;
        end
        return rnd;
    endfunction

    function automatic t_in_item random_req(input logic [1:0] cmd);
        t_in_item r;
        r.command    = cmd;
        r.modulation = pick16();
        r.pitch_bend = ($urandom_range(0, 3) == 0) ? 16'd16384 : pick16();
        r.velocity   = pick16();
        return r;
    endfunction

    function automatic t_script_row cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] val);
        t_script_row r;
        r.kind   = ROW_CFG;
        r.idx    = idx;
        r.val    = val;
        r.rq     = '0;
        r.pinned = '0;
        return r;
    endfunction

    function automatic t_script_row req_row(input logic [1:0] cmd, input logic [15:0] md,
                                            input logic [15:0] pb, input logic [15:0] vel);
        t_script_row r;
        r.kind          = ROW_REQ;
        r.idx           = '0;
        r.val           = '0;
        r.rq.command    = cmd;
        r.rq.modulation = md;
        r.rq.pitch_bend = pb;
        r.rq.velocity   = vel;
        r.pinned        = '0;
        return r;
    endfunction

    // a tick whose sample is plainly zero (no velocity or no envelope)
    function automatic t_script_row zero_row(input logic [15:0] md, input logic [15:0] pb,
                                             input logic [2:0] st);
        t_script_row r;
        r                  = req_row(CMD_TICK, md, pb, 16'h0000);
        r.kind             = ROW_PINNED;
        r.pinned.sample    = '0;
        r.pinned.env_phase = st;
        return r;
    endfunction

    task automatic send_request(input t_in_item rq, input bit pin, input t_out_item pin_res);
        int        gap;
        t_out_item res;
        bit        has;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        has = operator_step(rq, res);
        if (pin) begin
            expected_samples.insert(expected_samples.size(), pin_res);
        end else if (has) begin
            expected_samples.insert(expected_samples.size(), res);
        end
        sent_items++;
    endtask

    // drop the request line, let every sample arrive, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_PHASE_STEP:    r_phase_step = val[23:0];
            CFG_WAVE_SELECT:   r_wave       = val[1:0];
            CFG_AMPLITUDE:     r_amp        = val[15:0];
            CFG_MOD_DEPTH:     r_depth      = val[15:0];
            CFG_ATTACK_STEP:   r_attack     = val[23:0];
            CFG_DECAY_STEP:    r_decay      = val[23:0];
            CFG_SUSTAIN_LEVEL: r_sustain    = val[23:0];
            default:           r_release    = val[23:0];
        endcase
    endtask

    task automatic load_settings(input int ph);
        drain();
        write_reg(CFG_PHASE_STEP,    pick_cfg(ph, 24'd0, 24'($urandom())));
        write_reg(CFG_WAVE_SELECT,   pick_cfg(ph, 24'd0, 24'($urandom())));
        write_reg(CFG_AMPLITUDE,     pick_cfg(ph, 24'd0, {8'($urandom()), pick16()}));
        write_reg(CFG_MOD_DEPTH,     pick_cfg(ph, 24'd0, {8'($urandom()), pick16()}));
        write_reg(CFG_ATTACK_STEP,   pick_cfg(ph, 24'd1, pick_step()));
        write_reg(CFG_DECAY_STEP,    pick_cfg(ph, 24'd1, pick_step()));
        write_reg(CFG_SUSTAIN_LEVEL, pick_cfg(ph, 24'd0, pick_sustain()));
        write_reg(CFG_RELEASE_STEP,  pick_cfg(ph, 24'd1, pick_step()));
        i_cfg_valid <= 1'b0;
    endtask

    // output side: check each sample in order, then hold stall for a drawn count
    always @(posedge i_clk) begin : out_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                log_mismatch($sformatf("unexpected sample %0d stage %0d",
                                       o_out_data.sample, o_out_data.env_phase));
            end else begin
                want = expected_samples.pop_front();
                if (o_out_data.sample !== want.sample) begin
                    log_mismatch($sformatf("sample got %0d want %0d",
                                           o_out_data.sample, want.sample));
                end
                if (o_out_data.env_phase !== want.env_phase) begin
                    log_mismatch($sformatf("stage got %0d want %0d",
                                           o_out_data.env_phase, want.env_phase));
                end
            end
            stall_draw = no_idle ? 0 : $urandom_range(0, 4);
            stall_left = stall_draw;
            i_out_stall <= (stall_draw != 0);
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= (stall_left != 0);
        end
    end

    initial begin : watchdog
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int target;
        int n;

        // reset defaults: phase step zero, so the sine sits at zero phase
        add_row(req_row(CMD_TICK, 16'h0000, 16'h4000, 16'h0000));
        add_row(req_row(CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'hFFFF));
        add_row(req_row(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_row(req_row(CMD_NOTE_ON, 16'h0000, 16'h0000, 16'h0000));
        add_row(zero_row(16'h7FFF, 16'hFFFF, ST_ATTACK));
        // full-scale steps: attack, decay and release each end in one tick
        add_row(cfg_row(CFG_PHASE_STEP, 24'hFFFFFF));
        add_row(cfg_row(CFG_WAVE_SELECT, 24'(WAVE_SQUARE)));
        add_row(cfg_row(CFG_AMPLITUDE, 24'h00FFFF));
        add_row(cfg_row(CFG_MOD_DEPTH, 24'h00FFFF));
        add_row(cfg_row(CFG_ATTACK_STEP, 24'hFFFFFF));
        add_row(cfg_row(CFG_DECAY_STEP, 24'hFFFFFF));
        add_row(cfg_row(CFG_SUSTAIN_LEVEL, 24'h000000));
        add_row(cfg_row(CFG_RELEASE_STEP, 24'hFFFFFF));
        add_row(req_row(CMD_NOTE_ON, 16'h0000, 16'h0000, 16'hFFFF));
        add_row(req_row(CMD_TICK, 16'h8000, 16'hFFFF, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h7FFF, 16'hFFFF, 16'h0000));
        add_row(req_row(CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h1234, 16'h4000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h0000, 16'h4000, 16'h0000));
        // slow decay into full sustain, release restarts, retrigger
        add_row(cfg_row(CFG_WAVE_SELECT, 24'(WAVE_TRI)));
        add_row(cfg_row(CFG_ATTACK_STEP, 24'h400000));
        add_row(cfg_row(CFG_DECAY_STEP, 24'h000001));
        add_row(cfg_row(CFG_SUSTAIN_LEVEL, 24'hFFFFFF));
        add_row(cfg_row(CFG_RELEASE_STEP, 24'h800000));
        add_row(cfg_row(CFG_PHASE_STEP, 24'h123456));
        add_row(req_row(CMD_NOTE_ON, 16'h0000, 16'h0000, 16'h8000));
        add_row(req_row(CMD_TICK, 16'h0000, 16'h4000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h4000, 16'h8000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'hC000, 16'h0000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h8000, 16'hFFFF, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h7FFF, 16'h4000, 16'h0000));
        add_row(req_row(CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000));
        add_row(req_row(CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h0000, 16'h4000, 16'h0000));
        add_row(req_row(CMD_NOTE_ON, 16'h0000, 16'h0000, 16'h7FFF));
        add_row(req_row(CMD_TICK, 16'h0000, 16'h4000, 16'h0000));
        // zero steps: no stage ends by stepping
        add_row(cfg_row(CFG_WAVE_SELECT, 24'(WAVE_SAW)));
        add_row(cfg_row(CFG_ATTACK_STEP, 24'h000000));
        add_row(cfg_row(CFG_RELEASE_STEP, 24'h000000));
        add_row(req_row(CMD_NOTE_ON, 16'h0000, 16'h0000, 16'hFFFF));
        add_row(zero_row(16'h0000, 16'h0000, ST_ATTACK));
        add_row(req_row(CMD_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000));
        add_row(req_row(CMD_TICK, 16'h0000, 16'hFFFF, 16'h0000));
        add_row(cfg_row(CFG_WAVE_SELECT, 24'(WAVE_SINE)));
        add_row(req_row(CMD_TICK, 16'h5555, 16'hFFFF, 16'h0000));
        add_row(req_row(CMD_TICK, 16'hAAAA, 16'h4000, 16'h0000));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                drain();
                write_reg(script[i].idx, script[i].val);
                i_cfg_valid <= 1'b0;
            end else begin
                send_request(script[i].rq, script[i].kind == ROW_PINNED, script[i].pinned);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            load_settings(ph);
            no_idle = (ph % 4 == 3);
            target  = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(random_req(2'($urandom_range(0, 3))), 1'b0, '0);
                end else begin
                    send_request(random_req(CMD_NOTE_ON), 1'b0, '0);
                    n = $urandom_range(1, 30);
                    repeat (n) send_request(random_req(CMD_TICK), 1'b0, '0);
                    send_request(random_req(CMD_NOTE_OFF), 1'b0, '0);
                    n = $urandom_range(1, 30);
                    repeat (n) send_request(random_req(CMD_TICK), 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        for (n = 0; n < 1000 && expected_samples.size() != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            log_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
src/fmop_pkg.sv
src/fmop_ctrl.sv
src/fmop_dp.sv
src/fm_operator_with_adsr_core.sv
src/fmop_chk.sv
verif/fm_operator_with_adsr_core_tb.sv
